FILE: rtl/plm_pkg.sv
package plm_pkg;

  // field format
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int COEFF_W    = 18;
  localparam int ADDR_W     = 3;

  // derived widths
  localparam int DIFF_W  = DATA_WIDTH + 1;          // neighbor difference and magnitude
  localparam int SUM_W   = DATA_WIDTH + 2;          // a + b
  localparam int PROD_W  = 2 * DATA_WIDTH + 1;      // a * b, a * a
  localparam int P_LO_W  = DIFF_W;                  // low part of a * b
  localparam int P_HI_W  = PROD_W - P_LO_W;         // high part of a * b
  localparam int KA_W    = COEFF_W + DIFF_W;        // coefficient times magnitude
  localparam int NUM_W   = 3 * DATA_WIDTH + 2;      // dividend
  localparam int DEN_W   = 2 * DATA_WIDTH + 2;      // divisor
  localparam int QB      = DATA_WIDTH - 1;          // quotient bits below saturation
  localparam int MM_W    = DATA_WIDTH + 1;          // limiter magnitude

  localparam logic [MM_W-1:0] SAT_MAG = MM_W'(1) << (DATA_WIDTH - 1);

  // register indexes
  localparam logic REG_LIMITER_MODE = 1'b0;
  localparam logic REG_GM_COEFF     = 1'b1;

  localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(65536);

  typedef enum logic [1:0] {
    LIM_VAN_LEER   = 2'd0,
    LIM_MINMOD     = 2'd1,
    LIM_VAN_ALBADA = 2'd2,
    LIM_VL_MINMOD  = 2'd3
  } limiter_t;

  typedef struct packed {
    limiter_t             mode;
    logic [COEFF_W-1:0]   coeff;
  } cfg_t;

  // data that travels alongside the division
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] lv;
    logic signed [DATA_WIDTH-1:0] cv;
    logic signed [DATA_WIDTH-1:0] rv;
    logic                         agree;
    logic                         neg;
    logic [MM_W-1:0]              mm;
    logic                         ovf;
  } side_t;

endpackage

FILE: rtl/plm_cfg.sv
module plm_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [plm_pkg::ADDR_W-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output plm_pkg::cfg_t                   cfg
);

  logic                         wr;
  logic                         idx;
  plm_pkg::limiter_t            mode;
  logic [plm_pkg::COEFF_W-1:0]  coeff;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= plm_pkg::LIM_VAN_LEER;
      coeff <= plm_pkg::COEFF_RESET;
    end else if (wr) begin
      unique case (idx)
        plm_pkg::REG_LIMITER_MODE: mode  <= plm_pkg::limiter_t'(pwdata[1:0]);
        plm_pkg::REG_GM_COEFF:     coeff <= pwdata[plm_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      plm_pkg::REG_LIMITER_MODE: prdata = {30'd0, mode};
      plm_pkg::REG_GM_COEFF:     prdata = {{(32 - plm_pkg::COEFF_W){1'b0}}, coeff};
      default:                   prdata = '0;
    endcase
  end

  assign cfg.mode  = mode;
  assign cfg.coeff = coeff;

endmodule

FILE: rtl/plm_front.sv
module plm_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  plm_pkg::cfg_t                         cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [plm_pkg::DATA_WIDTH-1:0] lv,
  input  logic signed [plm_pkg::DATA_WIDTH-1:0] cv,
  input  logic signed [plm_pkg::DATA_WIDTH-1:0] rv,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output plm_pkg::side_t                        out_side,
  output logic [plm_pkg::NUM_W-1:0]             out_num,
  output logic [plm_pkg::DEN_W-1:0]             out_den
);

  localparam int DW = plm_pkg::DATA_WIDTH;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  plm_pkg::side_t sd1, sd2, sd3, sd4, sd5;
  plm_pkg::side_t sd1_next, sd2_next, sd4_next;

  logic signed [plm_pkg::DIFF_W-1:0] dl1, dr1;
  logic [plm_pkg::DIFF_W-1:0]        a2, b2;
  logic [plm_pkg::PROD_W-1:0]        p3, sqa3, sqb3, p4;
  logic [plm_pkg::SUM_W-1:0]         s3, s4;
  logic [plm_pkg::KA_W-1:0]          ka3, kb3;
  logic [plm_pkg::P_HI_W+plm_pkg::SUM_W-1:0] nhi4;
  logic [plm_pkg::P_LO_W+plm_pkg::SUM_W-1:0] nlo4;
  logic [plm_pkg::DEN_W-1:0]         dalb4;

  logic [2*plm_pkg::DIFF_W-1:0]      ab_full, aa_full, bb_full;
  logic [plm_pkg::KA_W-1:0]          ka_sh, kb_sh, mm_w;
  logic [plm_pkg::NUM_W-1:0]         num_alb;

  // ready chain, one stage at a time
  assign rdy5     = !v5 || out_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // side data updates
  always_comb begin
    sd1_next       = '0;
    sd1_next.lv    = lv;
    sd1_next.cv    = cv;
    sd1_next.rv    = rv;
    sd2_next       = sd1;
    sd2_next.agree = (dl1 > 0 && dr1 > 0) || (dl1 < 0 && dr1 < 0);
    sd2_next.neg   = dl1[plm_pkg::DIFF_W-1];
    sd4_next       = sd3;
    sd4_next.mm    = mm_w[plm_pkg::MM_W-1:0];
  end

  // products at full width
  always_comb begin
    ab_full = a2 * b2;
    aa_full = a2 * a2;
    bb_full = b2 * b2;
  end

  // generalized minmod magnitude
  always_comb begin
    ka_sh = ka3 >> plm_pkg::FRAC_BITS;
    kb_sh = kb3 >> plm_pkg::FRAC_BITS;
    mm_w  = (ka_sh < kb_sh) ? ka_sh : kb_sh;
    if (plm_pkg::KA_W'(s3 >> 1) < mm_w) mm_w = plm_pkg::KA_W'(s3 >> 1);
  end

  assign num_alb = (plm_pkg::NUM_W'(nhi4) << plm_pkg::P_LO_W) + plm_pkg::NUM_W'(nlo4);

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (rdy1) begin
      sd1 <= sd1_next;
      dl1 <= $signed({cv[DW-1], cv}) - $signed({lv[DW-1], lv});
      dr1 <= $signed({rv[DW-1], rv}) - $signed({cv[DW-1], cv});
    end
  end

  // stage 2: magnitudes and sign agreement
  always_ff @(posedge clk) begin
    if (rdy2) begin
      sd2 <= sd2_next;
      a2  <= dl1[plm_pkg::DIFF_W-1] ? plm_pkg::DIFF_W'(-dl1) : plm_pkg::DIFF_W'(dl1);
      b2  <= dl1[plm_pkg::DIFF_W-1] ? plm_pkg::DIFF_W'(-dr1) : plm_pkg::DIFF_W'(dr1);
    end
  end

  // stage 3: first products
  always_ff @(posedge clk) begin
    if (rdy3) begin
      sd3  <= sd2;
      p3   <= ab_full[plm_pkg::PROD_W-1:0];
      sqa3 <= aa_full[plm_pkg::PROD_W-1:0];
      sqb3 <= bb_full[plm_pkg::PROD_W-1:0];
      s3   <= plm_pkg::SUM_W'(a2) + plm_pkg::SUM_W'(b2);
      ka3  <= plm_pkg::KA_W'(cfg.coeff) * plm_pkg::KA_W'(a2);
      kb3  <= plm_pkg::KA_W'(cfg.coeff) * plm_pkg::KA_W'(b2);
    end
  end

  // stage 4: van albada partial products and denominator
  always_ff @(posedge clk) begin
    if (rdy4) begin
      sd4   <= sd4_next;
      nhi4  <= p3[plm_pkg::PROD_W-1:plm_pkg::P_LO_W] * s3;
      nlo4  <= p3[plm_pkg::P_LO_W-1:0] * s3;
      dalb4 <= plm_pkg::DEN_W'(sqa3) + plm_pkg::DEN_W'(sqb3);
      p4    <= p3;
      s4    <= s3;
    end
  end

  // stage 5: pick dividend and divisor
  always_ff @(posedge clk) begin
    if (rdy5) begin
      sd5 <= sd4;
      if (cfg.mode == plm_pkg::LIM_VAN_ALBADA) begin
        out_num <= num_alb;
        out_den <= dalb4;
      end else begin
        out_num <= plm_pkg::NUM_W'({p4, 1'b0});
        out_den <= plm_pkg::DEN_W'(s4);
      end
    end
  end

  assign out_valid = v5;
  assign out_side  = sd5;

endmodule

FILE: rtl/plm_div.sv
module plm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  plm_pkg::side_t              in_side,
  input  logic [plm_pkg::NUM_W-1:0]   in_num,
  input  logic [plm_pkg::DEN_W-1:0]   in_den,
  output logic                        out_valid,
  input  logic                        out_ready,
  output plm_pkg::side_t              out_side,
  output logic [plm_pkg::QB-1:0]      out_quo
);

  localparam int QB = plm_pkg::QB;

  logic                        vld [QB+1];
  logic                        rdy [QB+1];
  logic [plm_pkg::NUM_W-1:0]   rem [QB+1];
  logic [plm_pkg::DEN_W-1:0]   dv  [QB+1];
  logic [QB-1:0]               quo [QB+1];
  plm_pkg::side_t              sd  [QB+1];
  plm_pkg::side_t              sd0_next;

  // quotient above the saturation range
  always_comb begin
    sd0_next     = in_side;
    sd0_next.ovf = in_num >= (plm_pkg::NUM_W'(in_den) << QB);
  end

  assign in_ready = rdy[0];

  // stage 0: overflow check
  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (rdy[0]) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem[0] <= in_num;
      dv[0]  <= in_den;
      quo[0] <= '0;
      sd[0]  <= sd0_next;
    end
  end

  // restoring stages, one quotient bit each
  for (genvar j = 1; j <= QB; j++) begin : g_stage
    localparam int BIT = QB - j;
    logic [plm_pkg::NUM_W-1:0] dsh;
    logic                      ge;

    assign dsh = plm_pkg::NUM_W'(dv[j-1]) << BIT;
    assign ge  = rem[j-1] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else if (rdy[j]) vld[j] <= vld[j-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rem[j] <= ge ? rem[j-1] - dsh : rem[j-1];
        dv[j]  <= dv[j-1];
        quo[j] <= quo[j-1] | (ge ? (QB'(1) << BIT) : '0);
        sd[j]  <= sd[j-1];
      end
    end
  end

  // ready chain
  for (genvar j = 0; j < QB; j++) begin : g_rdy
    assign rdy[j] = !vld[j] || rdy[j+1];
  end
  assign rdy[QB] = !vld[QB] || out_ready;

  assign out_valid = vld[QB];
  assign out_side  = sd[QB];
  assign out_quo   = quo[QB];

endmodule

FILE: rtl/plm_back.sv
module plm_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  plm_pkg::cfg_t                          cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  plm_pkg::side_t                         in_side,
  input  logic [plm_pkg::QB-1:0]                 in_quo,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [plm_pkg::DATA_WIDTH-1:0]  slope,
  output logic signed [plm_pkg::DATA_WIDTH-1:0]  lface,
  output logic signed [plm_pkg::DATA_WIDTH-1:0]  rface
);

  localparam int DW = plm_pkg::DATA_WIDTH;
  localparam int XW = DW + 2;
  localparam logic signed [XW-1:0] FMAX = XW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [XW-1:0] FMIN = -FMAX - XW'(1);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [plm_pkg::MM_W-1:0]   divmag, mag;
  logic signed [DW-1:0]       slope_next;
  logic signed [DW-1:0]       slope1, cv1, lv1, rv1;
  logic signed [DW-1:0]       slope2, cv2, rv2, fl2;
  logic signed [DW-1:0]       slope3, cv3, fr3;
  logic signed [DW-1:0]       half;
  logic signed [XW-1:0]       xl, xr, xf;

  // clamp x between p and q
  function automatic logic signed [XW-1:0] clamp(input logic signed [XW-1:0] x,
                                                 input logic signed [XW-1:0] p,
                                                 input logic signed [XW-1:0] q);
    logic signed [XW-1:0] lo;
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] r;
    lo = (p < q) ? p : q;
    hi = (p < q) ? q : p;
    r  = x;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // limiter select and slope saturation
  always_comb begin
    divmag = in_side.ovf ? plm_pkg::SAT_MAG : plm_pkg::MM_W'(in_quo);
    unique case (cfg.mode)
      plm_pkg::LIM_VAN_LEER,
      plm_pkg::LIM_VAN_ALBADA: mag = divmag;
      plm_pkg::LIM_MINMOD:     mag = in_side.mm;
      plm_pkg::LIM_VL_MINMOD:  mag = (in_side.mm < divmag) ? in_side.mm : divmag;
      default:                 mag = divmag;
    endcase
    if (!in_side.agree) begin
      slope_next = '0;
    end else if (mag >= plm_pkg::SAT_MAG) begin
      slope_next = in_side.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      slope_next = in_side.neg ? -$signed(mag[DW-1:0]) : $signed(mag[DW-1:0]);
    end
  end

  // face arithmetic
  always_comb begin
    half = slope1 >>> 1;
    xl   = clamp(XW'(cv1) - XW'(half), XW'(cv1), XW'(lv1));
    xr   = clamp((XW'(cv2) <<< 1) - XW'(fl2), XW'(cv2), XW'(rv2));
    xf   = (XW'(cv3) <<< 1) - XW'(fr3);
    if (xf > FMAX) xf = FMAX;
    if (xf < FMIN) xf = FMIN;
  end

  // stage 1: slope
  always_ff @(posedge clk) begin
    if (rdy1) begin
      slope1 <= slope_next;
      cv1    <= in_side.cv;
      lv1    <= in_side.lv;
      rv1    <= in_side.rv;
    end
  end

  // stage 2: left face clamped toward the left neighbor
  always_ff @(posedge clk) begin
    if (rdy2) begin
      slope2 <= slope1;
      cv2    <= cv1;
      rv2    <= rv1;
      fl2    <= xl[DW-1:0];
    end
  end

  // stage 3: mirrored right face clamped toward the right neighbor
  always_ff @(posedge clk) begin
    if (rdy3) begin
      slope3 <= slope2;
      cv3    <= cv2;
      fr3    <= xr[DW-1:0];
    end
  end

  // stage 4: output register, left face mirrored back
  always_ff @(posedge clk) begin
    if (rdy4) begin
      slope <= slope3;
      rface <= fr3;
      lface <= xf[DW-1:0];
    end
  end

  assign out_valid = v4;

endmodule

FILE: rtl/plm_slope_limited_faces.sv
// an input transaction passes the differences and products, 32 divider stages and the faces
// on the way to its result; the restoring divider gives one quotient bit per restoring stage
// throughput: one transaction per cycle while the output is not stalled
// every stage holds its own valid bit, so bubbles fill while the output is stalled
// reset: synchronous, clears all valid bits, limiter mode to van leer, coefficient to 1.0
module plm_slope_limited_faces (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [plm_pkg::ADDR_W-1:0]             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [plm_pkg::DATA_WIDTH-1:0]  left_value,
  input  logic signed [plm_pkg::DATA_WIDTH-1:0]  center_value,
  input  logic signed [plm_pkg::DATA_WIDTH-1:0]  right_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [plm_pkg::DATA_WIDTH-1:0]  limited_slope,
  output logic signed [plm_pkg::DATA_WIDTH-1:0]  left_face,
  output logic signed [plm_pkg::DATA_WIDTH-1:0]  right_face
);

  plm_pkg::cfg_t                cfg;
  logic                         front_ready;
  logic                         fd_valid, fd_ready;
  plm_pkg::side_t               fd_side;
  logic [plm_pkg::NUM_W-1:0]    fd_num;
  logic [plm_pkg::DEN_W-1:0]    fd_den;
  logic                         db_valid, db_ready;
  plm_pkg::side_t               db_side;
  logic [plm_pkg::QB-1:0]       db_quo;

  // configuration registers
  plm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // differences, products, dividend selection
  plm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .lv        (left_value),
    .cv        (center_value),
    .rv        (right_value),
    .out_valid (fd_valid),
    .out_ready (fd_ready),
    .out_side  (fd_side),
    .out_num   (fd_num),
    .out_den   (fd_den)
  );

  // pipelined restoring divider
  plm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fd_valid),
    .in_ready  (fd_ready),
    .in_side   (fd_side),
    .in_num    (fd_num),
    .in_den    (fd_den),
    .out_valid (db_valid),
    .out_ready (db_ready),
    .out_side  (db_side),
    .out_quo   (db_quo)
  );

  // limiter select, slope and faces
  plm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (db_valid),
    .in_ready  (db_ready),
    .in_side   (db_side),
    .in_quo    (db_quo),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .slope     (limited_slope),
    .lface     (left_face),
    .rface     (right_face)
  );

  assign in_stall = !front_ready;

endmodule
